// ----- rtl/xxh64_word_stream_hash_defines.svh -----
// Assertion macros for the XXH64 word stream hash.
// Depends on nothing; taken in by the top level before its module header.
`ifndef XXH64_WORD_STREAM_HASH_DEFINES_SVH
`define XXH64_WORD_STREAM_HASH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define XXH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define XXH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/xxh_pkg.sv -----
// Shared types, constants and the microcode table of the XXH64 word stream hash.
// Depends on nothing; the top level, the multiplier and the sequencer import it.
`timescale 1ns / 1ps

package xxh_pkg;

	localparam logic [63:0] P1 = 64'd11400714785074694791;
	localparam logic [63:0] P2 = 64'd14029467366897019727;
	localparam logic [63:0] P3 = 64'd1609587929392839161;
	localparam logic [63:0] P4 = 64'd9650029242287828579;
	localparam logic [63:0] P12 = P1 + P2;

	localparam logic [63:0] SEED_RESET = 64'd4190307;
	localparam int unsigned MAX_WORDS_DEF = 512;

	// Datapath operation of one microcode step
	typedef enum logic [3:0] {
		OP_NOP,
		OP_MUL,
		OP_X_ADD_LANE,
		OP_LANE_WR,
		OP_H_CLR,
		OP_H_CONV,
		OP_H_XOR_X,
		OP_H_X_P4,
		OP_H_ADD_LEN,
		OP_H_XS33,
		OP_H_X_XS29,
		OP_H_X_XS32,
		OP_EMIT,
		OP_EMIT_ERR
	} dp_op_t;

	typedef enum logic [2:0] {
		A_WORD,
		A_ROT31_X,
		A_LANE,
		A_H,
		A_ROT27_H
	} a_sel_t;

	typedef enum logic [1:0] {
		B_P1,
		B_P2,
		B_P3
	} b_sel_t;

	typedef enum logic [1:0] {
		K_HOLD,
		K_INC,
		K_CLR
	} k_op_t;

	typedef enum logic [2:0] {
		J_NEXT,
		J_ALWAYS,
		J_K_NE3,
		J_NOT_LAST,
		J_TAIL_ZERO,
		J_K_NE_TAIL_END,
		J_DISPATCH
	} jcond_t;

	typedef enum logic [2:0] {
		MPH_IDLE,
		MPH_LL,
		MPH_LH,
		MPH_HL,
		MPH_SUM,
		MPH_DONE
	} mul_ph_t;

	typedef logic [4:0] upc_t;

	typedef struct packed {
		dp_op_t op;
		a_sel_t a_sel;
		b_sel_t b_sel;
		k_op_t  k_op;
		jcond_t jc;
		upc_t   target;
	} ucode_t;

	// Sequencer to datapath
	typedef struct packed {
		ucode_t     uw;
		logic [1:0] k;
		logic       fire;
		logic       mul_start;
		logic       idle;
	} ctrl_t;

	// Datapath to sequencer
	typedef struct packed {
		logic       in_acc;
		logic       stripe;
		logic       beat_last;
		logic       err;
		logic       msg_last;
		logic [1:0] tail;
		logic       mul_done;
		logic       out_free;
	} stat_t;

	localparam upc_t UPC_IDLE     = 5'd0;
	localparam upc_t UPC_ST_MIX   = 5'd1;
	localparam upc_t UPC_ST_ADD   = 5'd2;
	localparam upc_t UPC_ST_ROT   = 5'd3;
	localparam upc_t UPC_ST_WR    = 5'd4;
	localparam upc_t UPC_FIN      = 5'd5;
	localparam upc_t UPC_CONV     = 5'd6;
	localparam upc_t UPC_MRG_MIX  = 5'd7;
	localparam upc_t UPC_MRG_ROT  = 5'd8;
	localparam upc_t UPC_MRG_XOR  = 5'd9;
	localparam upc_t UPC_MRG_MUL  = 5'd10;
	localparam upc_t UPC_MRG_ADD  = 5'd11;
	localparam upc_t UPC_LEN      = 5'd12;
	localparam upc_t UPC_TL_MIX   = 5'd13;
	localparam upc_t UPC_TL_ROT   = 5'd14;
	localparam upc_t UPC_TL_XOR   = 5'd15;
	localparam upc_t UPC_TL_MUL   = 5'd16;
	localparam upc_t UPC_TL_ADD   = 5'd17;
	localparam upc_t UPC_AV_XS33  = 5'd18;
	localparam upc_t UPC_AV_MUL2  = 5'd19;
	localparam upc_t UPC_AV_XS29  = 5'd20;
	localparam upc_t UPC_AV_MUL3  = 5'd21;
	localparam upc_t UPC_AV_XS32  = 5'd22;
	localparam upc_t UPC_EMIT     = 5'd23;
	localparam upc_t UPC_ERR      = 5'd24;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
		return (x << r) | (x >> (7'd64 - {1'b0, r}));
	endfunction

	// Control store: one word per step
	function automatic ucode_t ucode_rom(input upc_t pc);
		ucode_t w;
		case (pc)
			UPC_IDLE:    w = '{OP_NOP,        A_H,       B_P1, K_CLR,  J_DISPATCH,      UPC_IDLE};
			UPC_ST_MIX:  w = '{OP_MUL,        A_WORD,    B_P2, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_ST_ADD:  w = '{OP_X_ADD_LANE, A_H,       B_P1, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_ST_ROT:  w = '{OP_MUL,        A_ROT31_X, B_P1, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_ST_WR:   w = '{OP_LANE_WR,    A_H,       B_P1, K_INC,  J_K_NE3,         UPC_ST_MIX};
			UPC_FIN:     w = '{OP_H_CLR,      A_H,       B_P1, K_CLR,  J_NOT_LAST,      UPC_IDLE};
			UPC_CONV:    w = '{OP_H_CONV,     A_H,       B_P1, K_INC,  J_K_NE3,         UPC_CONV};
			UPC_MRG_MIX: w = '{OP_MUL,        A_LANE,    B_P2, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_MRG_ROT: w = '{OP_MUL,        A_ROT31_X, B_P1, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_MRG_XOR: w = '{OP_H_XOR_X,    A_H,       B_P1, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_MRG_MUL: w = '{OP_MUL,        A_H,       B_P1, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_MRG_ADD: w = '{OP_H_X_P4,     A_H,       B_P1, K_INC,  J_K_NE3,         UPC_MRG_MIX};
			UPC_LEN:     w = '{OP_H_ADD_LEN,  A_H,       B_P1, K_CLR,  J_TAIL_ZERO,     UPC_AV_XS33};
			UPC_TL_MIX:  w = '{OP_MUL,        A_WORD,    B_P2, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_TL_ROT:  w = '{OP_MUL,        A_ROT31_X, B_P1, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_TL_XOR:  w = '{OP_H_XOR_X,    A_H,       B_P1, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_TL_MUL:  w = '{OP_MUL,        A_ROT27_H, B_P1, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_TL_ADD:  w = '{OP_H_X_P4,     A_H,       B_P1, K_INC,  J_K_NE_TAIL_END, UPC_TL_MIX};
			UPC_AV_XS33: w = '{OP_H_XS33,     A_H,       B_P1, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_AV_MUL2: w = '{OP_MUL,        A_H,       B_P2, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_AV_XS29: w = '{OP_H_X_XS29,   A_H,       B_P1, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_AV_MUL3: w = '{OP_MUL,        A_H,       B_P3, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_AV_XS32: w = '{OP_H_X_XS32,   A_H,       B_P1, K_HOLD, J_NEXT,          UPC_IDLE};
			UPC_EMIT:    w = '{OP_EMIT,       A_H,       B_P1, K_HOLD, J_ALWAYS,        UPC_IDLE};
			UPC_ERR:     w = '{OP_EMIT_ERR,   A_H,       B_P1, K_HOLD, J_ALWAYS,        UPC_IDLE};
			default:     w = '{OP_NOP,        A_H,       B_P1, K_CLR,  J_ALWAYS,        UPC_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/xxh_if.sv -----
// Handshake channel interfaces of the XXH64 word stream hash: word beats in, digests out.
// Depends on nothing.
`timescale 1ns / 1ps

interface xxh_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic        last_word;

	modport source (output valid, output data_word, output last_word, input ready);
	modport sink (input valid, input data_word, input last_word, output ready);
endinterface

interface xxh_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;
	logic        length_error;

	modport source (output valid, output hash_value, output length_error, input ready);
	modport sink (input valid, input hash_value, input length_error, output ready);
endinterface

// ----- rtl/xxh64_word_stream_hash.sv -----
// XXH64 word stream hash top level: word intake, hash datapath, digest register.
// Depends on xxh_pkg, xxh_if, xxh_mul, xxh_seq and the assertion macro header.
`timescale 1ns / 1ps
//
// Usage
//   msg    : one 64-bit little-endian message word per beat, last_word on the final beat.
//   digest : one beat per message, on its final word: hash_value and length_error.
//            A message under 4 words, or over MAX_WORDS, gives hash 0 with length_error.
//   hash_seed_we / hash_seed_wdata : seed register, sampled by the first word of a message.
// Sequence
//   A word that neither closes a stripe nor ends the message leaves the sequencer idle.
//   A word closing a 4-word stripe holds the input through four lane rounds, each two
//   multiplies plus two steps, then one step to test for the final word. After that step
//   the final word goes on to converge, merge, fold the tail and avalanche, then loads
//   the digest. The single iterative 64x64 multiplier (one 32x32 product per cycle)
//   computes every multiply of these rounds.
// Reset and stall
//   Reset clears the word count, the sequencer and the digest valid flag, and restores
//   the seed to its default. A digest waiting on a stalled receiver does not block
//   the next message; only the next digest waits for the register to drain.
`include "xxh64_word_stream_hash_defines.svh"

module xxh64_word_stream_hash import xxh_pkg::*; #(
	parameter int unsigned MAX_WORDS = MAX_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hash_seed_we,
	input  logic [63:0] hash_seed_wdata,
	xxh_in_if.sink      msg,
	xxh_out_if.source   digest
);

	localparam int unsigned CW = $clog2(MAX_WORDS + 2);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_WORDS);
	localparam logic [CW-1:0] SAT_C = CW'(MAX_WORDS + 1);
	localparam logic [CW-1:0] MIN_C = CW'(4);
	localparam logic [5:0] CONV_ROT [4] = '{6'd1, 6'd7, 6'd12, 6'd18};

	ctrl_t       ctrl;
	stat_t       stat;

	logic [63:0] seed_q;
	logic [CW-1:0] cnt_q, cnt_nxt, len_q;
	logic        last_q;
	logic [63:0] w_q, h_q, x_q;
	logic [63:0] lane_q [4];
	logic [63:0] pend_q [3];
	logic [63:0] lane_rd, word_rd, mul_a, mul_b, mul_p;
	logic        mul_done;
	logic        in_acc, sat, stripe, beat_err;
	logic        out_valid_q, out_err_q, out_free;
	logic [63:0] out_hash_q;

	// Word intake
	assign in_acc   = msg.valid && ctrl.idle;
	assign sat      = (cnt_q >= MAX_C);
	assign cnt_nxt  = sat ? SAT_C : CW'(cnt_q + 1'b1);
	assign stripe   = !sat && (cnt_q[1:0] == 2'd3);
	assign beat_err = (cnt_nxt < MIN_C) || (cnt_nxt > MAX_C);
	assign msg.ready = ctrl.idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else begin
			if (hash_seed_we) seed_q <= hash_seed_wdata;
			if (in_acc) begin
				cnt_q  <= msg.last_word ? '0 : cnt_nxt;
				last_q <= msg.last_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			w_q   <= msg.data_word;
			len_q <= cnt_nxt;
			if (!sat) begin
				case (cnt_q[1:0])
					2'd0:    pend_q[0] <= msg.data_word;
					2'd1:    pend_q[1] <= msg.data_word;
					2'd2:    pend_q[2] <= msg.data_word;
					default: ;
				endcase
			end
		end
	end

	// Lane accumulators: load from the seed on a message's first word, else take round results
	always_ff @(posedge clk) begin
		if (in_acc && cnt_q == '0) begin
			lane_q[0] <= seed_q + P12;
			lane_q[1] <= seed_q + P2;
			lane_q[2] <= seed_q;
			lane_q[3] <= seed_q - P1;
		end else if (ctrl.fire && ctrl.uw.op == OP_LANE_WR) begin
			lane_q[ctrl.k] <= x_q;
		end
	end

	assign lane_rd = lane_q[ctrl.k];

	// Held stripe words by lane; the fourth lane takes the word just taken
	always_comb begin
		case (ctrl.k)
			2'd0:    word_rd = pend_q[0];
			2'd1:    word_rd = pend_q[1];
			2'd2:    word_rd = pend_q[2];
			default: word_rd = w_q;
		endcase
	end

	always_comb begin
		case (ctrl.uw.a_sel)
			A_WORD:    mul_a = word_rd;
			A_ROT31_X: mul_a = rotl64(x_q, 6'd31);
			A_LANE:    mul_a = lane_rd;
			A_ROT27_H: mul_a = rotl64(h_q, 6'd27);
			default:   mul_a = h_q;
		endcase
		case (ctrl.uw.b_sel)
			B_P2:    mul_b = P2;
			B_P3:    mul_b = P3;
			default: mul_b = P1;
		endcase
	end

	xxh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	// Hash and scratch registers, advanced one microcode step at a time
	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			case (ctrl.uw.op)
				OP_MUL:        x_q <= mul_p;
				OP_X_ADD_LANE: x_q <= x_q + lane_rd;
				OP_H_CLR:      h_q <= '0;
				OP_H_CONV:     h_q <= h_q + rotl64(lane_rd, CONV_ROT[ctrl.k]);
				OP_H_XOR_X:    h_q <= h_q ^ x_q;
				OP_H_X_P4:     h_q <= x_q + P4;
				OP_H_ADD_LEN:  h_q <= h_q + 64'({len_q, 3'b000});
				OP_H_XS33:     h_q <= h_q ^ (h_q >> 33);
				OP_H_X_XS29:   h_q <= x_q ^ (x_q >> 29);
				OP_H_X_XS32:   h_q <= x_q ^ (x_q >> 32);
				default:       ;
			endcase
		end
	end

	// Digest register: drop on take, load on emit
	assign out_free = !out_valid_q || digest.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.fire && (ctrl.uw.op == OP_EMIT || ctrl.uw.op == OP_EMIT_ERR)) begin
			out_valid_q <= 1'b1;
		end else if (digest.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire && ctrl.uw.op == OP_EMIT) begin
			out_hash_q <= h_q;
			out_err_q  <= 1'b0;
		end else if (ctrl.fire && ctrl.uw.op == OP_EMIT_ERR) begin
			out_hash_q <= '0;
			out_err_q  <= 1'b1;
		end
	end

	assign digest.valid        = out_valid_q;
	assign digest.hash_value   = out_hash_q;
	assign digest.length_error = out_err_q;

	assign stat.in_acc    = in_acc;
	assign stat.stripe    = stripe;
	assign stat.beat_last = msg.last_word;
	assign stat.err       = beat_err;
	assign stat.msg_last  = last_q;
	assign stat.tail      = len_q[1:0];
	assign stat.mul_done  = mul_done;
	assign stat.out_free  = out_free;

	xxh_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	`XXH_ASSERT_NEXT(a_emit_loads, clk, arst_n, ctrl.fire && ctrl.uw.op == OP_EMIT, digest.valid && digest.hash_value == $past(h_q) && !digest.length_error, "digest not loaded from hash register")
	`XXH_ASSERT_NEXT(a_err_route, clk, arst_n, in_acc && msg.last_word && beat_err, ctrl.uw.op == OP_EMIT_ERR, "bad length did not route to error step")
	`XXH_ASSERT_NEXT(a_cnt_clear, clk, arst_n, in_acc && msg.last_word, cnt_q == '0, "word count not cleared after final word")
	`XXH_ASSERT_NOW(a_idle_no_mul, clk, arst_n, ctrl.idle, !mul_done && !ctrl.mul_start, "multiplier active while sequencer idle")

endmodule

// ----- rtl/xxh_mul.sv -----
// Iterative 64x64 low-half multiplier built on one 32x32 multiplier.
// Depends on xxh_pkg for the phase type.
`timescale 1ns / 1ps

module xxh_mul import xxh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);

	mul_ph_t     ph_q, ph_nxt;
	logic [63:0] a_q, b_q;
	logic [63:0] prod_q, acc_q;
	logic [31:0] op_a, op_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= MPH_IDLE;
		end else begin
			ph_q <= ph_nxt;
		end
	end

	always_comb begin
		ph_nxt = ph_q;
		case (ph_q)
			MPH_IDLE: if (start) ph_nxt = MPH_LL;
			MPH_LL:   ph_nxt = MPH_LH;
			MPH_LH:   ph_nxt = MPH_HL;
			MPH_HL:   ph_nxt = MPH_SUM;
			MPH_SUM:  ph_nxt = MPH_DONE;
			MPH_DONE: ph_nxt = MPH_IDLE;
			default:  ph_nxt = MPH_IDLE;
		endcase
	end

	// Cross products only feed the upper half, so keep their low 32 bits
	assign op_a = (ph_q == MPH_HL) ? a_q[63:32] : a_q[31:0];
	assign op_b = (ph_q == MPH_LH) ? b_q[63:32] : b_q[31:0];

	always_ff @(posedge clk) begin
		if (ph_q == MPH_IDLE && start) begin
			a_q <= a;
			b_q <= b;
		end
		prod_q <= 64'(op_a) * 64'(op_b);
		case (ph_q)
			MPH_LH:  acc_q <= prod_q;
			MPH_HL:  acc_q <= acc_q + {prod_q[31:0], 32'd0};
			MPH_SUM: acc_q <= acc_q + {prod_q[31:0], 32'd0};
			default: acc_q <= acc_q;
		endcase
	end

	assign done = (ph_q == MPH_DONE);
	assign p    = acc_q;

endmodule

// ----- rtl/xxh_seq.sv -----
// Microcode sequencer: step counter, control store lookup, lane index and jumps.
// Depends on xxh_pkg for the control word, status and control structs.
`timescale 1ns / 1ps

module xxh_seq import xxh_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	upc_t       upc_q, upc_nxt, dispatch;
	logic [1:0] k_q, k_nxt;
	logic       issued_q;
	ucode_t     uw;
	logic       fire, taken, mul_start;

	assign uw = ucode_rom(upc_q);

	always_comb begin
		fire = 1'b1;
		if (uw.jc == J_DISPATCH) begin
			fire = stat.in_acc;
		end else begin
			case (uw.op)
				OP_MUL:      fire = stat.mul_done;
				OP_EMIT:     fire = stat.out_free;
				OP_EMIT_ERR: fire = stat.out_free;
				default:     fire = 1'b1;
			endcase
		end
	end

	always_comb begin
		case (uw.jc)
			J_ALWAYS:        taken = 1'b1;
			J_K_NE3:         taken = (k_q != 2'd3);
			J_NOT_LAST:      taken = !stat.msg_last;
			J_TAIL_ZERO:     taken = (stat.tail == 2'd0);
			J_K_NE_TAIL_END: taken = (2'(k_q + 2'd1) != stat.tail);
			default:         taken = 1'b0;
		endcase
	end

	// Entry point chosen by the word just taken
	always_comb begin
		if (stat.stripe) begin
			dispatch = UPC_ST_MIX;
		end else if (stat.beat_last) begin
			dispatch = stat.err ? UPC_ERR : UPC_FIN;
		end else begin
			dispatch = UPC_IDLE;
		end
	end

	always_comb begin
		upc_nxt = upc_q;
		k_nxt   = k_q;
		if (fire) begin
			if (uw.jc == J_DISPATCH) begin
				upc_nxt = dispatch;
			end else if (taken) begin
				upc_nxt = uw.target;
			end else begin
				upc_nxt = 5'(upc_q + 5'd1);
			end
			case (uw.k_op)
				K_INC:   k_nxt = 2'(k_q + 2'd1);
				K_CLR:   k_nxt = 2'd0;
				default: k_nxt = k_q;
			endcase
		end
	end

	assign mul_start = (uw.op == OP_MUL) && !issued_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q    <= UPC_IDLE;
			k_q      <= 2'd0;
			issued_q <= 1'b0;
		end else begin
			upc_q    <= upc_nxt;
			k_q      <= k_nxt;
			issued_q <= fire ? 1'b0 : (issued_q | mul_start);
		end
	end

	assign ctrl.uw        = uw;
	assign ctrl.k         = k_q;
	assign ctrl.fire      = fire;
	assign ctrl.mul_start = mul_start;
	assign ctrl.idle      = (upc_q == UPC_IDLE);

endmodule
